### hdl/lts_pkg.sv
// Types and constants shared by the Lisp token scanner.
`default_nettype none

package lts_pkg;

  // Character codes the scanner treats specially.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  // Reserved words, left aligned in five character slots.
  localparam logic [39:0] WORD_NIL   = {"nil", 16'h0000};
  localparam logic [39:0] WORD_TRUE  = {"true", 8'h00};
  localparam logic [39:0] WORD_FALSE = "false";

  localparam logic [2:0] LEN_NIL   = 3'd3;
  localparam logic [2:0] LEN_TRUE  = 3'd4;
  localparam logic [2:0] LEN_FALSE = 3'd5;

  typedef enum logic [3:0] {
    KIND_OPEN    = 4'd0,
    KIND_CLOSE   = 4'd1,
    KIND_QUOTE   = 4'd2,
    KIND_SYMBOL  = 4'd3,
    KIND_TRUE    = 4'd4,
    KIND_FALSE   = 4'd5,
    KIND_NIL     = 4'd6,
    KIND_NUMBER  = 4'd7,
    KIND_STRING  = 4'd8,
    KIND_KEYWORD = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_END     = 2'd1,
    ST_UNEXP   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_SYMBOL  = 3'd2,
    MODE_KEYWORD = 3'd3,
    MODE_STRING  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    MATCH_NONE  = 2'd0,
    MATCH_NIL   = 2'd1,
    MATCH_TRUE  = 2'd2,
    MATCH_FALSE = 2'd3
  } match_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [31:0] pos;
    logic [15:0] len;
    logic        last;
  } res_t;

  localparam int OUT_DATA_BITS = 56;

endpackage : lts_pkg

`default_nettype wire

### hdl/lisp_token_scanner.sv
// Lisp token scanner: one character word in, token result words out.
// Result words are registered in the result queue. Throughput: one character word per cycle
// while the queue has room; the single result output moves one word per cycle when taken,
// so a character that both ends a token and starts one yields two result words.
// A four-entry result queue decouples the two sides; input is taken while two slots are free.
// Reset clears the scanner state, the position and length counts and the result queue.
`default_nettype none

module lisp_token_scanner #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  wire logic        s_axis_tlast_i,   // end_of_input
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [lts_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
                                             // [3:0] token_kind, [35:4] token_position,
                                             // [51:36] token_length, [55:52] zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  output logic             m_axis_tlast_o    // last_result
);

  lts_pkg::mode_e            mode_q, mode_d;
  lts_pkg::match_e           match_q, match_d;
  logic                      esc_q, esc_d;
  logic                      stop_q, stop_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d, pos_inc;
  logic [LENGTH_BITS-1:0]    len_q, len_d, len_inc;

  lts_pkg::res_t             fifo_q [4];
  logic [1:0]                wr_ptr_q, rd_ptr_q;
  logic [2:0]                cnt_q, cnt_d;

  lts_pkg::res_t             res0, res1, fin_res, start_res;
  logic [1:0]                n_res;
  logic                      s_acc, m_pop, start_emit, finishing;
  logic                      is_dig, is_alp;
  logic [7:0]                ch;
  logic [63:0]               pos_q_ext, pos_inc_ext;
  logic [31:0]               len_q_ext;
  logic [31:0]               pos_q_rep, pos_inc_rep;
  logic [15:0]               len_q_rep;
  logic [2:0]                wlen;
  lts_pkg::kind_e            word_kind, sym_kind;

  function automatic logic [7:0] want_char(lts_pkg::match_e m, logic [2:0] i);
    logic [39:0] w;
    w = '0;
    unique case (m)
      lts_pkg::MATCH_NIL:   w = lts_pkg::WORD_NIL;
      lts_pkg::MATCH_TRUE:  w = lts_pkg::WORD_TRUE;
      lts_pkg::MATCH_FALSE: w = lts_pkg::WORD_FALSE;
      default:              w = '0;
    endcase
    if (i > 3'd4) return 8'h00;
    return w[39 - 8 * int'(i) -: 8];
  endfunction

  function automatic lts_pkg::res_t mk_res(lts_pkg::kind_e k, lts_pkg::status_e s,
                                           logic [31:0] p, logic [15:0] l);
    lts_pkg::res_t r;
    r.kind   = k;
    r.status = s;
    r.pos    = p;
    r.len    = l;
    r.last   = 1'b0;
    return r;
  endfunction

  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_pop           = m_axis_tvalid_o && m_axis_tready_i;

  assign ch     = s_axis_tdata_i;
  assign is_dig = (ch >= "0") && (ch <= "9");
  assign is_alp = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));

  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

  // Reported counts are the low bits of the internal saturating counts.
  assign pos_q_ext   = 64'(pos_q);
  assign pos_inc_ext = 64'(pos_inc);
  assign len_q_ext   = 32'(len_q);
  assign pos_q_rep   = pos_q_ext[31:0];
  assign pos_inc_rep = pos_inc_ext[31:0];
  assign len_q_rep   = len_q_ext[15:0];

  always_comb begin
    unique case (match_q)
      lts_pkg::MATCH_NIL:   wlen = lts_pkg::LEN_NIL;
      lts_pkg::MATCH_TRUE:  wlen = lts_pkg::LEN_TRUE;
      lts_pkg::MATCH_FALSE: wlen = lts_pkg::LEN_FALSE;
      default:              wlen = 3'd0;
    endcase
  end

  always_comb begin
    sym_kind = lts_pkg::KIND_SYMBOL;
    if (match_q != lts_pkg::MATCH_NONE && len_q_ext == 32'(wlen)) begin
      unique case (match_q)
        lts_pkg::MATCH_NIL:  sym_kind = lts_pkg::KIND_NIL;
        lts_pkg::MATCH_TRUE: sym_kind = lts_pkg::KIND_TRUE;
        default:             sym_kind = lts_pkg::KIND_FALSE;
      endcase
    end
  end

  always_comb begin
    unique case (mode_q)
      lts_pkg::MODE_NUMBER: word_kind = lts_pkg::KIND_NUMBER;
      lts_pkg::MODE_SYMBOL: word_kind = sym_kind;
      default:              word_kind = lts_pkg::KIND_KEYWORD;
    endcase
  end

  assign finishing = (mode_q == lts_pkg::MODE_NUMBER) || (mode_q == lts_pkg::MODE_SYMBOL) ||
                     (mode_q == lts_pkg::MODE_KEYWORD);

  always_comb begin
    mode_d     = mode_q;
    match_d    = match_q;
    esc_d      = esc_q;
    stop_d     = stop_q;
    pos_d      = pos_q;
    len_d      = len_q;
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;
    start_emit = 1'b0;
    start_res  = '0;
    fin_res    = mk_res(word_kind, lts_pkg::ST_VALID, pos_q_rep, len_q_rep);
    if (s_acc && !stop_q) begin
      if (s_axis_tlast_i) begin
        stop_d = 1'b1;
        if (mode_q == lts_pkg::MODE_STRING) begin
          res0  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_UNEXP, pos_q_rep, 16'd0);
          n_res = 2'd1;
        end else if (mode_q == lts_pkg::MODE_KEYWORD && len_q == '0) begin
          res0  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_INVALID, pos_q_rep, 16'd0);
          n_res = 2'd1;
        end else begin
          mode_d = lts_pkg::MODE_IDLE;
          if (finishing) begin
            res0  = fin_res;
            res1  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_END, pos_q_rep, 16'd0);
            n_res = 2'd2;
          end else begin
            res0  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_END, pos_q_rep, 16'd0);
            n_res = 2'd1;
          end
        end
      end else begin
        pos_d = pos_inc;
        if (mode_q == lts_pkg::MODE_STRING) begin
          if (!esc_q && ch == lts_pkg::CH_DQUOTE) begin
            res0   = mk_res(lts_pkg::KIND_STRING, lts_pkg::ST_VALID, pos_inc_rep, len_q_rep);
            n_res  = 2'd1;
            mode_d = lts_pkg::MODE_IDLE;
            len_d  = '0;
          end else begin
            len_d = len_inc;
            esc_d = !esc_q && ch == lts_pkg::CH_BSLASH;
          end
        end else if (mode_q == lts_pkg::MODE_NUMBER && is_dig) begin
          len_d = len_inc;
        end else if ((mode_q == lts_pkg::MODE_SYMBOL || mode_q == lts_pkg::MODE_KEYWORD) &&
                     (is_dig || is_alp)) begin
          // A reserved-word candidate drops out on the first character that differs or runs past it.
          if (mode_q == lts_pkg::MODE_SYMBOL && match_q != lts_pkg::MATCH_NONE &&
              (len_q_ext >= 32'(wlen) || ch != want_char(match_q, len_q[2:0]))) begin
            match_d = lts_pkg::MATCH_NONE;
          end
          len_d = len_inc;
        end else if (mode_q == lts_pkg::MODE_KEYWORD && len_q == '0) begin
          res0   = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_INVALID, pos_inc_rep, 16'd0);
          n_res  = 2'd1;
          stop_d = 1'b1;
        end else begin
          // Close any pending word, then scan this character as a fresh start.
          mode_d  = lts_pkg::MODE_IDLE;
          len_d   = '0;
          match_d = lts_pkg::MATCH_NONE;
          esc_d   = 1'b0;
          priority if (ch == lts_pkg::CH_SPACE || ch == lts_pkg::CH_TAB ||
                       ch == lts_pkg::CH_NL) begin
            start_emit = 1'b0;
          end else if (ch == lts_pkg::CH_OPEN) begin
            start_emit = 1'b1;
            start_res  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_VALID, pos_inc_rep, 16'd1);
          end else if (ch == lts_pkg::CH_CLOSE) begin
            start_emit = 1'b1;
            start_res  = mk_res(lts_pkg::KIND_CLOSE, lts_pkg::ST_VALID, pos_inc_rep, 16'd1);
          end else if (ch == lts_pkg::CH_QUOTE) begin
            start_emit = 1'b1;
            start_res  = mk_res(lts_pkg::KIND_QUOTE, lts_pkg::ST_VALID, pos_inc_rep, 16'd1);
          end else if (is_dig) begin
            mode_d = lts_pkg::MODE_NUMBER;
            len_d  = LENGTH_BITS'(1);
          end else if (is_alp) begin
            mode_d = lts_pkg::MODE_SYMBOL;
            len_d  = LENGTH_BITS'(1);
            priority if (ch == lts_pkg::CH_LOW_N) match_d = lts_pkg::MATCH_NIL;
            else if (ch == lts_pkg::CH_LOW_T) match_d = lts_pkg::MATCH_TRUE;
            else if (ch == lts_pkg::CH_LOW_F) match_d = lts_pkg::MATCH_FALSE;
            else match_d = lts_pkg::MATCH_NONE;
          end else if (ch == lts_pkg::CH_COLON) begin
            mode_d = lts_pkg::MODE_KEYWORD;
          end else if (ch == lts_pkg::CH_DQUOTE) begin
            mode_d = lts_pkg::MODE_STRING;
          end else begin
            start_emit = 1'b1;
            start_res  = mk_res(lts_pkg::KIND_OPEN, lts_pkg::ST_INVALID, pos_inc_rep, 16'd0);
            stop_d     = 1'b1;
          end
          if (finishing) begin
            res0  = fin_res;
            res1  = start_res;
            n_res = start_emit ? 2'd2 : 2'd1;
          end else if (start_emit) begin
            res0  = start_res;
            n_res = 2'd1;
          end
        end
      end
    end
    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  assign cnt_d = cnt_q + 3'(n_res) - 3'(m_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lts_pkg::MODE_IDLE;
      match_q  <= lts_pkg::MATCH_NONE;
      esc_q    <= 1'b0;
      stop_q   <= 1'b0;
      pos_q    <= '0;
      len_q    <= '0;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      mode_q   <= mode_d;
      match_q  <= match_d;
      esc_q    <= esc_d;
      stop_q   <= stop_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      wr_ptr_q <= wr_ptr_q + n_res;
      rd_ptr_q <= rd_ptr_q + 2'(m_pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= res1;
  end

  assign m_axis_tdata_o = {4'b0000, fifo_q[rd_ptr_q].len, fifo_q[rd_ptr_q].pos,
                           fifo_q[rd_ptr_q].kind};
  assign m_axis_tuser_o = fifo_q[rd_ptr_q].status;
  assign m_axis_tlast_o = fifo_q[rd_ptr_q].last;

  // Once stopped, the scanner stays stopped until reset.
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("scanner left the stopped state without reset");

  // End of input always stops the scanner.
  a_eoi_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> stop_q)
    else $error("end of input did not stop the scanner");

  // The result queue never overflows.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  // A status word carries no token kind or length and closes its item.
  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != lts_pkg::ST_VALID) |->
      (m_axis_tdata_o[3:0] == 4'd0 && m_axis_tdata_o[51:36] == 16'd0 && m_axis_tlast_o))
    else $error("malformed status word");

  // Nothing new enters the queue after the scanner has stopped.
  a_no_push_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stop_q && !m_pop) |=> (cnt_q == $past(cnt_q)))
    else $error("result produced while stopped");

endmodule : lisp_token_scanner

`default_nettype wire
